// ----- hdl/rv32_ex_pkg.sv -----
// Package for the RV32I execute stage: payload structs, command classes, constants.
// No dependencies.
package rv32_ex_pkg;
    localparam int MEM_BYTES_DEF = 65536;

    localparam logic [3:0] CMD_REG_ALU = 4'd0;
    localparam logic [3:0] CMD_IMM_ALU = 4'd1;
    localparam logic [3:0] CMD_LOAD    = 4'd2;
    localparam logic [3:0] CMD_JALR    = 4'd3;
    localparam logic [3:0] CMD_STORE   = 4'd4;
    localparam logic [3:0] CMD_BRANCH  = 4'd5;
    localparam logic [3:0] CMD_LUI     = 4'd6;
    localparam logic [3:0] CMD_AUIPC   = 4'd7;
    localparam logic [3:0] CMD_JAL     = 4'd8;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BYTE  = 3'd0;
    localparam logic [2:0] F3_HALF  = 3'd1;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;
    localparam logic [2:0] F3_HALFU = 3'd5;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [2:0]  func3;
        logic        alt_op;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic signed [31:0] imm_value;
        logic        compressed;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic        branch_taken;
    } out_item_t;

    // classified instruction handed from front to back
    typedef struct packed {
        in_item_t    item;
        logic        is_load;
        logic        is_store;
        logic        wr_rd;
    } dec_item_t;
endpackage

// ----- hdl/rv32_ex_ram.sv -----
// Generic RAM with one write port and one read port, with registered read.
// No dependencies.
module rv32_ex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/rv32_ex_front.sv -----
// Front end: accepts instruction beats, classifies them, feeds a two-entry queue.
// Depends on rv32_ex_pkg.
module rv32_ex_front
    import rv32_ex_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      q_valid,
    input  logic      q_ready,
    output dec_item_t q_data
);
    dec_item_t  ent_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] cnt_reg;
    dec_item_t  dec;
    logic       push;
    logic       pop;

    always_comb
    begin
        dec.item     = in_data;
        dec.is_load  = (in_data.cmd == CMD_LOAD);
        dec.is_store = (in_data.cmd == CMD_STORE);
        case (in_data.cmd)
            CMD_REG_ALU, CMD_IMM_ALU, CMD_JALR, CMD_LUI, CMD_AUIPC, CMD_JAL:
                dec.wr_rd = 1'b1;
            CMD_LOAD:
                dec.wr_rd = (in_data.func3 == F3_BYTE) || (in_data.func3 == F3_HALF)
                         || (in_data.func3 == F3_WORD) || (in_data.func3 == F3_BYTEU)
                         || (in_data.func3 == F3_HALFU);
            default:
                dec.wr_rd = 1'b0;
        endcase
        if (in_data.dest_reg == 5'd0)
        begin
            dec.wr_rd = 1'b0;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = ent_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- hdl/rv32_ex_back.sv -----
// Back end: register file, pc, ALU, branch unit, byte-lane data memory.
// Depends on rv32_ex_pkg and rv32_ex_ram.
module rv32_ex_back
    import rv32_ex_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  dec_item_t q_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int LW = AW - 2;
    localparam int LDEPTH = MEM_BYTES / 4;

    logic [31:0] rf_reg [32];
    logic [31:0] rf_next [32];
    logic [31:0] pc_reg;
    logic [31:0] pc_next;

    // stage 1: execute; stage 2: load data returns
    logic        s2_valid_reg;
    logic        s2_load_reg;
    logic [2:0]  s2_f3_reg;
    logic [1:0]  s2_off_reg;
    out_item_t   s2_item_reg;
    logic        s2_wr_reg;
    logic        stall;

    logic        ov_reg;
    out_item_t   od_reg;

    logic [31:0] a, b, imm, ea, opb, alu_val, step, val, npc, wval;
    logic [4:0]  sh;
    logic        taken, cond, slt, sltu, fire, wr;
    logic [7:0]  lane_rd [4];
    logic [7:0]  lane_wd [4];
    logic        lane_we [4];
    logic [LW-1:0] lane_addr [4];
    logic [AW-1:0] ea_m;
    logic [31:0] raw;
    logic [7:0]  byte_sel;
    logic [15:0] half_sel;
    logic [31:0] ld_val;
    logic [31:0] wb_val;
    in_item_t    it;

    assign it   = q_data.item;
    assign a    = (it.src1_reg == 5'd0) ? 32'd0 : rf_reg[it.src1_reg];
    assign b    = (it.src2_reg == 5'd0) ? 32'd0 : rf_reg[it.src2_reg];
    assign imm  = it.imm_value;
    assign ea   = a + imm;
    assign ea_m = ea[AW-1:0];
    assign step = it.compressed ? 32'd2 : 32'd4;
    assign opb  = (it.cmd == CMD_REG_ALU) ? b : imm;
    assign sh   = opb[4:0];
    assign slt  = $signed(a) < $signed(opb);
    assign sltu = a < opb;

    always_comb
    begin
        case (it.func3)
            F3_ADD:  alu_val = (it.alt_op && it.cmd == CMD_REG_ALU) ? a - opb : a + opb;
            F3_SLL:  alu_val = a << sh;
            F3_SLT:  alu_val = {31'd0, slt};
            F3_SLTU: alu_val = {31'd0, sltu};
            F3_XOR:  alu_val = a ^ opb;
            F3_SR:   alu_val = it.alt_op ? 32'($signed(a) >>> sh) : a >> sh;
            F3_OR:   alu_val = a | opb;
            default: alu_val = a & opb;
        endcase
        case (it.func3)
            F3_BEQ:  cond = (a == b);
            F3_BNE:  cond = (a != b);
            F3_BLT:  cond = $signed(a) < $signed(b);
            F3_BGE:  cond = !($signed(a) < $signed(b));
            F3_BLTU: cond = a < b;
            F3_BGEU: cond = a >= b;
            default: cond = 1'b0;
        endcase
        npc   = pc_reg + step;
        taken = 1'b0;
        val   = 32'd0;
        unique case (it.cmd)
            CMD_REG_ALU, CMD_IMM_ALU: val = alu_val;
            CMD_JALR:
            begin
                val   = pc_reg + step;
                npc   = {ea[31:1], 1'b0};
                taken = 1'b1;
            end
            CMD_BRANCH:
            begin
                if (cond)
                begin
                    npc   = pc_reg + imm;
                    taken = 1'b1;
                end
            end
            CMD_LUI:   val = {imm[19:0], 12'd0};
            CMD_AUIPC: val = pc_reg + {imm[19:0], 12'd0};
            CMD_JAL:
            begin
                val   = pc_reg + step;
                npc   = pc_reg + imm;
                taken = 1'b1;
            end
            default: val = 32'd0;
        endcase
    end

    // a load result returns next cycle; hold an item that needs a register it writes
    assign stall = s2_valid_reg && s2_load_reg && s2_wr_reg &&
                   ((s2_item_reg.write_index == it.src1_reg) ||
                    (s2_item_reg.write_index == it.src2_reg));
    assign q_ready = !stall && (!s2_valid_reg || !ov_reg || out_ready);
    assign fire    = q_valid && q_ready;
    assign wr      = q_data.wr_rd;
    assign wval    = wr ? val : 32'd0;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            logic [1:0]    k;
            logic [AW-1:0] ba;
            logic [1:0]    rel;
            logic [LW-1:0] hold_reg;
            assign k   = 2'(g);
            // byte address of lane g inside the word window starting at ea
            assign rel = k - ea_m[1:0];
            assign ba  = ea_m + AW'(rel);
            assign lane_addr[g] = ba[AW-1:2];
            assign lane_wd[g]   = b[8*rel +: 8];
            assign lane_we[g]   = fire && q_data.is_store &&
                                  ((it.func3 == F3_WORD) ||
                                   (it.func3 == F3_HALF && rel < 2'd2) ||
                                   (it.func3 == F3_BYTE && rel == 2'd0));
            // hold the read address while stage 2 waits
            always_ff @(posedge clk)
            begin
                if (fire)
                begin
                    hold_reg <= lane_addr[g];
                end
            end
            rv32_ex_ram #(.WIDTH(8), .DEPTH(LDEPTH)) u_lane (
                .clk   (clk),
                .we    (lane_we[g]),
                .waddr (lane_addr[g]),
                .wdata (lane_wd[g]),
                .raddr (fire ? lane_addr[g] : hold_reg),
                .rdata (lane_rd[g])
            );
        end
    endgenerate

    always_comb
    begin
        raw = {lane_rd[s2_off_reg + 2'd3], lane_rd[s2_off_reg + 2'd2],
               lane_rd[s2_off_reg + 2'd1], lane_rd[s2_off_reg]};
        byte_sel = raw[7:0];
        half_sel = raw[15:0];
        case (s2_f3_reg)
            F3_BYTE:  ld_val = {{24{byte_sel[7]}}, byte_sel};
            F3_HALF:  ld_val = {{16{half_sel[15]}}, half_sel};
            F3_BYTEU: ld_val = {24'd0, byte_sel};
            F3_HALFU: ld_val = {16'd0, half_sel};
            default:  ld_val = raw;
        endcase
        wb_val = (s2_load_reg && s2_wr_reg) ? ld_val : s2_item_reg.write_value;
    end

    always_comb
    begin
        pc_next = fire ? npc : pc_reg;
        rf_next = rf_reg;
        if (s2_valid_reg && s2_load_reg && s2_wr_reg)
        begin
            rf_next[s2_item_reg.write_index] = ld_val;
        end
        if (fire && wr && !q_data.is_load)
        begin
            rf_next[it.dest_reg] = val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= 32'd0;
            s2_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
            for (int i = 0; i < 32; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
        end
        else
        begin
            pc_reg <= pc_next;
            rf_reg <= rf_next;
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (s2_valid_reg && (!ov_reg || out_ready))
            begin
                ov_reg <= 1'b1;
            end
            if (fire)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (!ov_reg || out_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s2_load_reg              <= q_data.is_load;
            s2_f3_reg                <= it.func3;
            s2_off_reg               <= ea_m[1:0];
            s2_wr_reg                <= wr;
            s2_item_reg.next_pc      <= npc;
            s2_item_reg.reg_written  <= wr;
            s2_item_reg.write_index  <= wr ? it.dest_reg : 5'd0;
            s2_item_reg.write_value  <= wval;
            s2_item_reg.branch_taken <= taken;
        end
        if (s2_valid_reg && (!ov_reg || out_ready))
        begin
            od_reg             <= s2_item_reg;
            od_reg.write_value <= wb_val;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule

// ----- hdl/rv32i_execute_stage.sv -----
// RV32I execute stage: one result beat per instruction beat.
// An input beat passes the queue, execute and load return before its result beat.
// Throughput: one beat per cycle while out_ready is high; a load followed by a user of its
// destination is held until the load data has been written to the register file.
// Reset clears pc, register file and queues; data memory is not cleared.
// Depends on rv32_ex_pkg, rv32_ex_front, rv32_ex_back.
module rv32i_execute_stage
    import rv32_ex_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    logic      q_valid;
    logic      q_ready;
    dec_item_t q_data;

    rv32_ex_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    rv32_ex_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule
